>>> sv/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
`default_nettype none
package qrs_pkg;

    localparam int CoefW = 16;               // Q8.8 coefficient
    localparam int RootW = 32;               // Q16.16 root
    localparam int DiscW = 34;               // signed b*b - 4*a*c
    localparam int RadW  = 64;               // sqrt radicand, disc << 30
    localparam int SqrtW = RadW / 2;         // sqrt result bits, one per stage
    localparam int RemW  = SqrtW + 2;        // sqrt partial remainder
    localparam int NumW  = 35;               // signed numerator -b*2^15 +/- s
    localparam int XW    = 35;               // 2|n| + |a|, dividend bits
    localparam int DvW   = CoefW + 1;        // 2|a|, divisor bits
    localparam int FracShift = 15;
    localparam int RadShift  = 30;

    typedef enum logic [1:0] {
        StTwo    = 2'd0,
        StDouble = 2'd1,
        StNone   = 2'd2,
        StAZero  = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [CoefW-1:0] coef_a;
        logic signed [CoefW-1:0] coef_b;
        logic signed [CoefW-1:0] coef_c;
    } coef_t;

    typedef struct packed {
        logic signed [RootW-1:0] root_plus;
        logic signed [RootW-1:0] root_minus;
        status_t                 root_status;
        logic                    saturated;
    } root_t;

    // side data that rides along the sqrt pipeline
    typedef struct packed {
        logic signed [CoefW-1:0] a;
        logic signed [CoefW-1:0] b;
        status_t                 status;
    } sq_tag_t;

endpackage
`default_nettype wire

>>> sv/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module qrs_sqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire logic [qrs_pkg::RadW-1:0]    in_rad,
    input  wire qrs_pkg::sq_tag_t            in_tag,
    output logic                             out_vld,
    output logic [qrs_pkg::SqrtW-1:0]        out_root,
    output qrs_pkg::sq_tag_t                 out_tag
);

    localparam int SqrtW = qrs_pkg::SqrtW;
    localparam int RemW  = qrs_pkg::RemW;
    localparam int RadW  = qrs_pkg::RadW;

    logic                   vld  [SqrtW+1];
    logic [RemW-1:0]        rem  [SqrtW+1];
    logic [SqrtW-1:0]       root [SqrtW+1];
    logic [RadW-1:0]        rad  [SqrtW+1];
    qrs_pkg::sq_tag_t       tag  [SqrtW+1];

    assign vld[0]  = in_vld;
    assign rem[0]  = '0;
    assign root[0] = '0;
    assign rad[0]  = in_rad;
    assign tag[0]  = in_tag;

    for (genvar g = 0; g < SqrtW; g++) begin : g_stage
        logic [RemW+1:0]   cur;
        logic [RemW+1:0]   trial;
        logic [RemW+1:0]   diff;
        logic              ge;
        logic [RemW-1:0]   rem_next;
        logic [SqrtW-1:0]  root_next;
        logic              vld_reg;
        logic [RemW-1:0]   rem_reg;
        logic [SqrtW-1:0]  root_reg;
        logic [RadW-1:0]   rad_reg;
        qrs_pkg::sq_tag_t  tag_reg;

        always_comb
        begin
            cur       = {rem[g], rad[g][RadW-1 -: 2]};
            trial     = {2'b00, root[g], 2'b01};
            ge        = (cur >= trial);
            diff      = cur - trial;
            rem_next  = ge ? diff[RemW-1:0] : cur[RemW-1:0];
            root_next = {root[g][SqrtW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld[g];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                rad_reg  <= {rad[g][RadW-3:0], 2'b00};
                tag_reg  <= tag[g];
            end
        end

        assign vld[g+1]  = vld_reg;
        assign rem[g+1]  = rem_reg;
        assign root[g+1] = root_reg;
        assign rad[g+1]  = rad_reg;
        assign tag[g+1]  = tag_reg;
    end

    assign out_vld  = vld[SqrtW];
    assign out_root = root[SqrtW];
    assign out_tag  = tag[SqrtW];

endmodule
`default_nettype wire

>>> sv/qrs_div.sv
// Two-lane pipelined divider: rounded n/a, ties away from zero, clipped to Q16.16.
`default_nettype none
module qrs_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_vld,
    input  wire logic signed [qrs_pkg::NumW-1:0]   num_p,
    input  wire logic signed [qrs_pkg::NumW-1:0]   num_m,
    input  wire logic signed [qrs_pkg::CoefW-1:0]  den,
    input  wire qrs_pkg::status_t                  in_status,
    output logic                                   out_vld,
    output logic signed [qrs_pkg::RootW-1:0]       out_p,
    output logic signed [qrs_pkg::RootW-1:0]       out_m,
    output logic                                   out_sat_p,
    output logic                                   out_sat_m,
    output qrs_pkg::status_t                       out_status
);

    localparam int XW    = qrs_pkg::XW;
    localparam int DvW   = qrs_pkg::DvW;
    localparam int NumW  = qrs_pkg::NumW;
    localparam int CoefW = qrs_pkg::CoefW;
    localparam int RootW = qrs_pkg::RootW;
    localparam logic [XW-1:0] PosMax = XW'((64'd1 << (RootW-1)) - 64'd1);
    localparam logic [XW-1:0] NegMax = XW'(64'd1 << (RootW-1));

    // prep stage: magnitudes, rounding offset, signs
    logic [NumW-1:0]  num [2];
    logic [NumW-1:0]  mag [2];
    logic [CoefW-1:0] den_mag;
    logic             neg_next [2];
    logic [XW-1:0]    x_next [2];

    assign num[0] = num_p;
    assign num[1] = num_m;

    always_comb
    begin
        den_mag = den[CoefW-1] ? CoefW'(-den) : den;
        for (int l = 0; l < 2; l++)
        begin
            mag[l]      = num[l][NumW-1] ? NumW'(-num[l]) : num[l];
            neg_next[l] = num[l][NumW-1] ^ den[CoefW-1];
            x_next[l]   = {mag[l][XW-2:0], 1'b0} + XW'(den_mag);
        end
    end

    logic                vld  [XW+1];
    logic [DvW-1:0]      dv   [XW+1];
    qrs_pkg::status_t    st   [XW+1];
    logic [1:0]          sgn  [XW+1];
    logic [XW-1:0]       x    [XW+1][2];
    logic [DvW-1:0]      r    [XW+1][2];
    logic [XW-1:0]       q    [XW+1][2];

    logic              prep_vld_reg;
    logic [DvW-1:0]    prep_dv_reg;
    qrs_pkg::status_t  prep_st_reg;
    logic [1:0]        prep_sgn_reg;
    logic [XW-1:0]     prep_x_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_vld_reg <= 1'b0;
        else if (en)
            prep_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_dv_reg   <= {den_mag, 1'b0};
            prep_st_reg   <= in_status;
            prep_sgn_reg  <= {neg_next[1], neg_next[0]};
            prep_x_reg[0] <= x_next[0];
            prep_x_reg[1] <= x_next[1];
        end
    end

    assign vld[0] = prep_vld_reg;
    assign dv[0]  = prep_dv_reg;
    assign st[0]  = prep_st_reg;
    assign sgn[0] = prep_sgn_reg;
    for (genvar l = 0; l < 2; l++) begin : g_lane0
        assign x[0][l] = prep_x_reg[l];
        assign r[0][l] = '0;
        assign q[0][l] = '0;
    end

    // restoring division, one quotient bit per stage
    for (genvar g = 0; g < XW; g++) begin : g_stage
        logic              vld_reg;
        logic [DvW-1:0]    dv_reg;
        qrs_pkg::status_t  st_reg;
        logic [1:0]        sgn_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld[g];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg  <= dv[g];
                st_reg  <= st[g];
                sgn_reg <= sgn[g];
            end
        end

        assign vld[g+1] = vld_reg;
        assign dv[g+1]  = dv_reg;
        assign st[g+1]  = st_reg;
        assign sgn[g+1] = sgn_reg;

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DvW:0]    cur;
            logic [DvW:0]    diff;
            logic            ge;
            logic [DvW-1:0]  r_next;
            logic [XW-1:0]   x_reg;
            logic [DvW-1:0]  r_reg;
            logic [XW-1:0]   q_reg;

            always_comb
            begin
                cur    = {r[g][l], x[g][l][XW-1]};
                ge     = (cur >= {1'b0, dv[g]});
                diff   = cur - {1'b0, dv[g]};
                r_next = ge ? diff[DvW-1:0] : cur[DvW-1:0];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg <= {x[g][l][XW-2:0], 1'b0};
                    r_reg <= r_next;
                    q_reg <= {q[g][l][XW-2:0], ge};
                end
            end

            assign x[g+1][l] = x_reg;
            assign r[g+1][l] = r_reg;
            assign q[g+1][l] = q_reg;
        end
    end

    // sign and clip
    logic [RootW-1:0] res_next [2];
    logic             sat_next [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (sgn[XW][l])
            begin
                sat_next[l] = (q[XW][l] > NegMax);
                res_next[l] = sat_next[l] ? NegMax[RootW-1:0]
                                          : RootW'(-q[XW][l][RootW-1:0]);
            end
            else
            begin
                sat_next[l] = (q[XW][l] > PosMax);
                res_next[l] = sat_next[l] ? PosMax[RootW-1:0] : q[XW][l][RootW-1:0];
            end
        end
    end

    logic              fin_vld_reg;
    logic [RootW-1:0]  fin_p_reg;
    logic [RootW-1:0]  fin_m_reg;
    logic              fin_sat_p_reg;
    logic              fin_sat_m_reg;
    qrs_pkg::status_t  fin_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_vld_reg <= 1'b0;
        else if (en)
            fin_vld_reg <= vld[XW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_p_reg     <= res_next[0];
            fin_m_reg     <= res_next[1];
            fin_sat_p_reg <= sat_next[0];
            fin_sat_m_reg <= sat_next[1];
            fin_st_reg    <= st[XW];
        end
    end

    assign out_vld    = fin_vld_reg;
    assign out_p      = fin_p_reg;
    assign out_m      = fin_m_reg;
    assign out_sat_p  = fin_sat_p_reg;
    assign out_sat_m  = fin_sat_m_reg;
    assign out_status = fin_st_reg;

endmodule
`default_nettype wire

>>> sv/quadratic_root_solver.sv
// Throughput: one beat per cycle unless stalled; the 32-stage square root and
// the divider's 35 restoring stages each take one bit per stage, so a new item
// can enter on every cycle that coef_ready is high. The pipeline advances as one;
// coef_ready drops only while a result sits unread in the output register.
// Reset clears all valid bits, nothing else.
`default_nettype none
module quadratic_root_solver (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            coef_valid,
    output logic                 coef_ready,
    input  wire qrs_pkg::coef_t  coef,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output qrs_pkg::root_t       res
);

    localparam int CoefW = qrs_pkg::CoefW;
    localparam int DiscW = qrs_pkg::DiscW;
    localparam int RadW  = qrs_pkg::RadW;
    localparam int SqrtW = qrs_pkg::SqrtW;
    localparam int NumW  = qrs_pkg::NumW;
    localparam int RootW = qrs_pkg::RootW;

    logic en;
    logic res_valid_reg;

    assign en         = !res_valid_reg || res_ready;
    assign coef_ready = en;

    // input register
    logic                     in_vld_reg;
    qrs_pkg::coef_t           in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (en)
            in_vld_reg <= coef_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            in_reg <= coef;
    end

    // products
    logic                      mul_vld_reg;
    logic signed [2*CoefW-1:0] bb_reg;
    logic signed [2*CoefW-1:0] ac_reg;
    logic signed [CoefW-1:0]   mul_a_reg;
    logic signed [CoefW-1:0]   mul_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_vld_reg <= 1'b0;
        else if (en)
            mul_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb_reg    <= in_reg.coef_b * in_reg.coef_b;
            ac_reg    <= in_reg.coef_a * in_reg.coef_c;
            mul_a_reg <= in_reg.coef_a;
            mul_b_reg <= in_reg.coef_b;
        end
    end

    // discriminant and classification
    logic signed [DiscW-1:0] disc;
    qrs_pkg::status_t        status_next;
    logic [RadW-1:0]         rad_next;
    logic                    disc_vld_reg;
    logic [RadW-1:0]         rad_reg;
    qrs_pkg::sq_tag_t        disc_tag_reg;

    always_comb
    begin
        disc = DiscW'(bb_reg) - {ac_reg, 2'b00};
        if (mul_a_reg == '0)
            status_next = qrs_pkg::StAZero;
        else if (disc[DiscW-1])
            status_next = qrs_pkg::StNone;
        else if (disc == '0)
            status_next = qrs_pkg::StDouble;
        else
            status_next = qrs_pkg::StTwo;
        rad_next = (status_next == qrs_pkg::StTwo)
                 ? RadW'({disc[DiscW-2:0], {qrs_pkg::RadShift{1'b0}}}) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            disc_vld_reg <= 1'b0;
        else if (en)
            disc_vld_reg <= mul_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg             <= rad_next;
            disc_tag_reg.a      <= mul_a_reg;
            disc_tag_reg.b      <= mul_b_reg;
            disc_tag_reg.status <= status_next;
        end
    end

    logic              sq_vld;
    logic [SqrtW-1:0]  sq_root;
    qrs_pkg::sq_tag_t  sq_tag;

    qrs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (disc_vld_reg),
        .in_rad   (rad_reg),
        .in_tag   (disc_tag_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_tag  (sq_tag)
    );

    // numerators -b*2^15 +/- s
    logic signed [NumW-1:0] base;
    logic                   num_vld_reg;
    logic signed [NumW-1:0] num_p_reg;
    logic signed [NumW-1:0] num_m_reg;
    logic signed [CoefW-1:0] num_a_reg;
    qrs_pkg::status_t       num_st_reg;

    assign base = (NumW'(0) - NumW'(sq_tag.b)) <<< qrs_pkg::FracShift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_vld_reg <= 1'b0;
        else if (en)
            num_vld_reg <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_p_reg  <= base + $signed(NumW'(sq_root));
            num_m_reg  <= base - $signed(NumW'(sq_root));
            num_a_reg  <= sq_tag.a;
            num_st_reg <= sq_tag.status;
        end
    end

    logic                    dv_vld;
    logic signed [RootW-1:0] dv_p;
    logic signed [RootW-1:0] dv_m;
    logic                    dv_sat_p;
    logic                    dv_sat_m;
    qrs_pkg::status_t        dv_st;

    qrs_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (num_vld_reg),
        .num_p      (num_p_reg),
        .num_m      (num_m_reg),
        .den        (num_a_reg),
        .in_status  (num_st_reg),
        .out_vld    (dv_vld),
        .out_p      (dv_p),
        .out_m      (dv_m),
        .out_sat_p  (dv_sat_p),
        .out_sat_m  (dv_sat_m),
        .out_status (dv_st)
    );

    // output register
    qrs_pkg::root_t res_next;
    qrs_pkg::root_t res_reg;

    always_comb
    begin
        res_next.root_status = dv_st;
        case (dv_st)
            qrs_pkg::StTwo:
            begin
                res_next.root_plus  = dv_p;
                res_next.root_minus = dv_m;
                res_next.saturated  = dv_sat_p | dv_sat_m;
            end
            qrs_pkg::StDouble:
            begin
                res_next.root_plus  = dv_p;
                res_next.root_minus = '0;
                res_next.saturated  = dv_sat_p;
            end
            default:
            begin
                res_next.root_plus  = '0;
                res_next.root_minus = '0;
                res_next.saturated  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_minus_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.root_status != qrs_pkg::StTwo |-> res.root_minus == '0)
        else $error("root_minus nonzero without two roots");

    a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.root_status == qrs_pkg::StNone ||
                      res.root_status == qrs_pkg::StAZero)
        |-> res.root_plus == '0 && !res.saturated)
        else $error("nonzero output without real roots");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.saturated && res.root_status == qrs_pkg::StDouble
        |-> res.root_plus == RootW'(32'h7fff_ffff) ||
            res.root_plus == RootW'(32'h8000_0000))
        else $error("saturated double root not at a rail");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(dv_p) && $stable(sq_root))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire

>>> tb/qrs_checker.sv
// Checker for the quadratic root solver: watches both channels, predicts and compares.
module qrs_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            coef_valid,
    input  logic            coef_ready,
    input  qrs_pkg::coef_t  coef,
    input  logic            res_valid,
    input  logic            res_ready,
    input  qrs_pkg::root_t  res,
    output int              errors,
    output int              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    qrs_pkg::root_t roots_due[$];

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > v)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (v >= r + bt)
            begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end
            else
                r = r >> 1;
            bt = bt >> 2;
        end
        return r;
    endfunction

    // n / d, rounded half away from zero, clipped to 32 bits
    function automatic logic signed [31:0] div_round(input longint n, input longint d,
                                                     inout logic sat);
        logic neg;
        longint un, ud, q;
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (2 * un + ud) / (2 * ud);
        if (neg)
        begin
            if (q > 64'sd2147483648)
            begin
                sat = 1'b1;
                q = 64'sd2147483648;
            end
            return 32'(-q);
        end
        if (q > 64'sd2147483647)
        begin
            sat = 1'b1;
            q = 64'sd2147483647;
        end
        return 32'(q);
    endfunction

    function automatic qrs_pkg::root_t solve_roots(input qrs_pkg::coef_t cf);
        qrs_pkg::root_t rt;
        longint a, b, c, disc, base, s;
        logic   sat;
        a = cf.coef_a;
        b = cf.coef_b;
        c = cf.coef_c;
        sat = 1'b0;
        rt = '0;
        if (a == 0)
            rt.root_status = qrs_pkg::StAZero;
        else
        begin
            disc = b * b - 4 * a * c;
            base = -b * 32768;
            if (disc < 0)
                rt.root_status = qrs_pkg::StNone;
            else if (disc == 0)
            begin
                rt.root_status = qrs_pkg::StDouble;
                rt.root_plus = div_round(base, a, sat);
            end
            else
            begin
                rt.root_status = qrs_pkg::StTwo;
                s = longint'(isqrt(64'(disc) << 30));
                rt.root_plus = div_round(base + s, a, sat);
                rt.root_minus = div_round(base - s, a, sat);
            end
        end
        rt.saturated = sat;
        return rt;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t: %s mismatch: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        qrs_pkg::root_t want;
        if (rst_n)
        begin
            if (coef_valid && coef_ready)
                roots_due.push_back(solve_roots(coef));
            if (res_valid && res_ready)
            begin
                if (roots_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat", $realtime);
                    errors++;
                end
                else
                begin
                    want = roots_due.pop_front();
                    if (res.root_plus !== want.root_plus)
                        report("root_plus", res.root_plus, want.root_plus);
                    if (res.root_minus !== want.root_minus)
                        report("root_minus", res.root_minus, want.root_minus);
                    if (res.root_status !== want.root_status)
                        report("root_status", res.root_status, want.root_status);
                    if (res.saturated !== want.saturated)
                        report("saturated", res.saturated, want.saturated);
                end
            end
        end
        pending = roots_due.size();
    end
endmodule

>>> tb/testbench.sv
// Top of the quadratic root solver testbench: stimulus, watchdog and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 73;
    localparam int STALL_MAX = 10000;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           coef_valid = 1'b0;
    logic           coef_ready;
    qrs_pkg::coef_t coef = '0;
    logic           res_valid;
    logic           res_ready = 1'b0;
    qrs_pkg::root_t res;
    int             errors;
    int             pending;
    int             quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    quadratic_root_solver i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef_valid(coef_valid),
        .coef_ready(coef_ready),
        .coef      (coef),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    qrs_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef_valid(coef_valid),
        .coef_ready(coef_ready),
        .coef      (coef),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .errors    (errors),
        .pending   (pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(0, 3);
    endfunction

    // receiver: random stalls, with calm stretches
    initial
    begin
        int hold;
        @(posedge clk iff rst_n);
        forever
        begin
            if ($urandom_range(0, 3) == 0)
                hold = gap_len();
            else
                hold = 0;
            if ($urandom_range(0, 7) == 0)
            begin
                res_ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end
            res_ready <= (hold == 0);
            repeat (hold == 0 ? 1 : hold) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((coef_valid && coef_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_coef(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
        coef_valid <= 1'b1;
        coef <= '{coef_a: a, coef_b: b, coef_c: c};
        @(posedge clk);
        while (!coef_ready)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int n);
        coef_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
            1: return 16'($signed(16'($urandom_range(0, 64))) - 16'sd32);
            2: return 16'($urandom_range(0, 1) ? 16'h0100 : 16'hff00);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] a, b, c;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: degenerate, no roots, double roots, extremes, saturation
        send_coef(16'h0000, 16'h1234, 16'h5678);
        send_coef(16'h0000, 16'h0000, 16'h0000);
        send_coef(16'h0100, 16'h0000, 16'h0100);
        send_coef(16'h0100, 16'h0000, 16'h0000);
        send_coef(16'h0100, 16'hfc00, 16'h0400);
        send_coef(16'h0100, 16'h0000, 16'hff00);
        send_coef(16'h0100, 16'hfd00, 16'h0200);
        send_coef(16'h0001, 16'h7fff, 16'h0000);
        send_coef(16'h0001, 16'h8000, 16'h0000);
        send_coef(16'hffff, 16'h8000, 16'h7fff);
        send_coef(16'h7fff, 16'h7fff, 16'h8000);
        send_coef(16'h8000, 16'h8000, 16'h7fff);
        send_coef(16'h8000, 16'h7fff, 16'h8000);
        send_coef(16'h7fff, 16'h8000, 16'h7fff);
        send_coef(16'h8000, 16'h0000, 16'h8000);
        send_coef(16'hffff, 16'hffff, 16'hffff);
        send_coef(16'h0001, 16'h0002, 16'h0001);
        send_coef(16'hff00, 16'h0200, 16'hff00);
        send_coef(16'h0002, 16'h0001, 16'h0000);
        send_coef(16'h5555, 16'haaaa, 16'h5555);

        // sender pause: let everything drain
        coef_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        for (int i = 0; i < 1100; i++)
        begin
            a = rand_coef();
            b = rand_coef();
            c = rand_coef();
            // steer some items onto double roots: b even, c = b^2/(4a) with a = 1/256
            if ($urandom_range(0, 9) == 0)
            begin
                a = 16'h0001;
                b = 16'($urandom_range(0, 181) * 2);
                c = 16'((b / 2) * (b / 2));
                if ($urandom_range(0, 1))
                    b = -b;
            end
            send_coef(a, b, c);
            if ($urandom_range(0, 3) == 0)
                pause_sender(gap_len());
        end
        coef_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
